// File: hw/rtl/mcpi_pkg.sv
// Shared types, constants and the step sequence of the Monte Carlo pi sampler.
package mcpi_pkg;

   // Seed value; mixing constants as 32-bit halves for the shared multiplier.
   localparam logic [63:0] SEED_K    = 64'h243f6a8885a308d3;
   localparam logic [31:0] SEED_C1_LO = 32'h7f4a7c15;
   localparam logic [31:0] SEED_C1_HI = 32'h9e3779b9;
   localparam logic [31:0] SEED_C2_LO = 32'h1ce4e5b9;
   localparam logic [31:0] SEED_C2_HI = 32'hbf58476d;

   // xorshift64* output multiplier (2685821657736338717).
   localparam logic [31:0] GEN_MULT_LO = 32'h4f6cdd1d;
   localparam logic [31:0] GEN_MULT_HI = 32'h2545f491;

   localparam int XS_SHIFT_A = 12;
   localparam int XS_SHIFT_B = 25;
   localparam int XS_SHIFT_C = 27;

   localparam int FRAC_W   = 53;              // x, y as Q0.53
   localparam int FRAC_LSB = 64 - FRAC_W;     // drop 11 low bits of the draw
   localparam int SQ_W     = 2 * FRAC_W + 1;  // Q1.106 sum of squares
   localparam int COUNT_W  = 48;

   localparam int          STEP_W    = 5;
   localparam logic [4:0]  STEP_SEED = 5'd0;
   localparam logic [4:0]  STEP_DRAW = 5'd8;
   localparam logic [4:0]  STEP_LAST = 5'd27;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_FOLD,      // gen ^= acc, acc = 0
      OP_STEP,      // gen = xorshift(gen), acc = 0
      OP_FRAC,      // frac = acc[63:11], acc = 0
      OP_COUNT,     // compare, count, load result register
      OP_M_W_C1L,
      OP_M_W_C1H,
      OP_M_R_C2L,
      OP_M_R_C2H,
      OP_M_G_LL,
      OP_M_G_LH,
      OP_M_G_HL,
      OP_M_F_LL,
      OP_M_F_LH,
      OP_M_F_HH
   } op_type;

   // Where a registered product is added in the following cycle.
   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_ACC_LO,
      TAG_ACC_HI,
      TAG_SQ0,
      TAG_SQ1,
      TAG_SQ2
   } tag_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

   // Microcode: seeding at steps 0-7, two draws and squares at 8-26, count at 27.
   function automatic op_type step_op(input logic [4:0] step);
      op_type op;
      case (step)
         5'd0:    op = OP_M_W_C1L;
         5'd1:    op = OP_M_W_C1H;
         5'd2:    op = OP_NOP;
         5'd3:    op = OP_FOLD;
         5'd4:    op = OP_M_R_C2L;
         5'd5:    op = OP_M_R_C2H;
         5'd6:    op = OP_NOP;
         5'd7:    op = OP_FOLD;
         5'd8:    op = OP_STEP;
         5'd9:    op = OP_M_G_LL;
         5'd10:   op = OP_M_G_LH;
         5'd11:   op = OP_M_G_HL;
         5'd12:   op = OP_NOP;
         5'd13:   op = OP_FRAC;
         5'd14:   op = OP_M_F_LL;
         5'd15:   op = OP_M_F_LH;
         5'd16:   op = OP_M_F_HH;
         5'd17:   op = OP_STEP;
         5'd18:   op = OP_M_G_LL;
         5'd19:   op = OP_M_G_LH;
         5'd20:   op = OP_M_G_HL;
         5'd21:   op = OP_NOP;
         5'd22:   op = OP_FRAC;
         5'd23:   op = OP_M_F_LL;
         5'd24:   op = OP_M_F_LH;
         5'd25:   op = OP_M_F_HH;
         5'd26:   op = OP_NOP;
         5'd27:   op = OP_COUNT;
         default: op = OP_NOP;
      endcase
      return op;
   endfunction

   function automatic logic [63:0] xorshift(input logic [63:0] s);
      logic [63:0] t;
      t = s ^ (s >> XS_SHIFT_A);
      t = t ^ (t << XS_SHIFT_B);
      t = t ^ (t >> XS_SHIFT_C);
      return t;
   endfunction

endpackage

// File: hw/rtl/mcpi_ctrl.sv
// Sequencer for the sampler: accepts a request and steps through the microcode.
module mcpi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_start_req,
   output logic                 req_stall,
   input  mcpi_pkg::status_type status,
   output mcpi_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd.load = 1'b0;
      cmd.op   = mcpi_pkg::OP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
               step_in  = req_start_req ? mcpi_pkg::STEP_SEED : mcpi_pkg::STEP_DRAW;
            end
         end
         ST_RUN: begin
            if (step_ff == mcpi_pkg::STEP_LAST) begin
               // hold the count step until the result register is free
               if (!status.out_full) begin
                  cmd.op   = mcpi_pkg::OP_COUNT;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.op  = mcpi_pkg::step_op(step_ff);
               step_in = step_ff + 5'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= mcpi_pkg::STEP_SEED;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: hw/rtl/mcpi_datapath.sv
// Generator state, shared 32x32 multiplier, accumulators, hit counter and result register.
module mcpi_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mcpi_pkg::cmd_type    cmd,
   output mcpi_pkg::status_type status,
   input  logic                 req_start_req,
   input  logic [15:0]          req_rep_number,
   input  logic                 csr_valid,
   input  logic [15:0]          csr_worker_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [47:0]          rsp_hit_count
);

   logic [15:0]            widx_ff, widx_in;
   logic [15:0]            rep_ff, rep_in;
   logic [63:0]            gen_ff, gen_in;
   logic [63:0]            acc_ff, acc_in;
   logic [52:0]            frac_ff, frac_in;
   logic [106:0]           sq_ff, sq_in;
   logic [47:0]            count_ff, count_in;
   logic [63:0]            prod_ff, prod_in;
   mcpi_pkg::tag_type      tag_ff, tag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [47:0]            rsp_count_ff, rsp_count_in;

   logic [16:0]            w_plus1;
   logic [31:0]            mul_a, mul_b;
   logic                   hit;

   assign w_plus1 = {1'b0, widx_ff} + 17'd1;
   assign hit     = !sq_ff[106] || (sq_ff[105:0] == 106'd0);

   assign status.out_full = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hit_count   = rsp_count_ff;

   // operand select and product destination
   always_comb begin
      mul_a  = 32'd0;
      mul_b  = 32'd0;
      tag_in = mcpi_pkg::TAG_NONE;
      case (cmd.op)
         mcpi_pkg::OP_M_W_C1L: begin
            mul_a = {15'd0, w_plus1}; mul_b = mcpi_pkg::SEED_C1_LO;
            tag_in = mcpi_pkg::TAG_ACC_LO;
         end
         mcpi_pkg::OP_M_W_C1H: begin
            mul_a = {15'd0, w_plus1}; mul_b = mcpi_pkg::SEED_C1_HI;
            tag_in = mcpi_pkg::TAG_ACC_HI;
         end
         mcpi_pkg::OP_M_R_C2L: begin
            mul_a = {16'd0, rep_ff}; mul_b = mcpi_pkg::SEED_C2_LO;
            tag_in = mcpi_pkg::TAG_ACC_LO;
         end
         mcpi_pkg::OP_M_R_C2H: begin
            mul_a = {16'd0, rep_ff}; mul_b = mcpi_pkg::SEED_C2_HI;
            tag_in = mcpi_pkg::TAG_ACC_HI;
         end
         mcpi_pkg::OP_M_G_LL: begin
            mul_a = gen_ff[31:0]; mul_b = mcpi_pkg::GEN_MULT_LO;
            tag_in = mcpi_pkg::TAG_ACC_LO;
         end
         mcpi_pkg::OP_M_G_LH: begin
            mul_a = gen_ff[31:0]; mul_b = mcpi_pkg::GEN_MULT_HI;
            tag_in = mcpi_pkg::TAG_ACC_HI;
         end
         mcpi_pkg::OP_M_G_HL: begin
            mul_a = gen_ff[63:32]; mul_b = mcpi_pkg::GEN_MULT_LO;
            tag_in = mcpi_pkg::TAG_ACC_HI;
         end
         mcpi_pkg::OP_M_F_LL: begin
            mul_a = frac_ff[31:0]; mul_b = frac_ff[31:0];
            tag_in = mcpi_pkg::TAG_SQ0;
         end
         mcpi_pkg::OP_M_F_LH: begin
            mul_a = frac_ff[31:0]; mul_b = {11'd0, frac_ff[52:32]};
            tag_in = mcpi_pkg::TAG_SQ1;
         end
         mcpi_pkg::OP_M_F_HH: begin
            mul_a = {11'd0, frac_ff[52:32]}; mul_b = {11'd0, frac_ff[52:32]};
            tag_in = mcpi_pkg::TAG_SQ2;
         end
         default: begin
            tag_in = mcpi_pkg::TAG_NONE;
         end
      endcase
   end

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      widx_in      = csr_valid ? csr_worker_index : widx_ff;
      rep_in       = rep_ff;
      gen_in       = gen_ff;
      acc_in       = acc_ff;
      frac_in      = frac_ff;
      sq_in        = sq_ff;
      count_in     = count_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // add last cycle's product
      case (tag_ff)
         mcpi_pkg::TAG_ACC_LO: acc_in = acc_ff + prod_ff;
         mcpi_pkg::TAG_ACC_HI: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         mcpi_pkg::TAG_SQ0:    sq_in  = sq_ff + {43'd0, prod_ff};
         mcpi_pkg::TAG_SQ1:    sq_in  = sq_ff + {21'd0, prod_ff[52:0], 33'd0};
         mcpi_pkg::TAG_SQ2:    sq_in  = sq_ff + {1'b0, prod_ff[41:0], 64'd0};
         default: begin
            acc_in = acc_ff;
         end
      endcase

      if (cmd.load) begin
         rep_in = req_rep_number;
         acc_in = 64'd0;
         sq_in  = 107'd0;
         if (req_start_req) begin
            gen_in   = mcpi_pkg::SEED_K;
            count_in = 48'd0;
         end
      end

      case (cmd.op)
         mcpi_pkg::OP_FOLD: begin
            gen_in = gen_ff ^ acc_ff;
            acc_in = 64'd0;
         end
         mcpi_pkg::OP_STEP: begin
            gen_in = mcpi_pkg::xorshift(gen_ff);
            acc_in = 64'd0;
         end
         mcpi_pkg::OP_FRAC: begin
            frac_in = acc_ff[63:mcpi_pkg::FRAC_LSB];
            acc_in  = 64'd0;
         end
         mcpi_pkg::OP_COUNT: begin
            // saturating count
            if (hit && (count_ff != {48{1'b1}})) begin
               count_in     = count_ff + 48'd1;
               rsp_count_in = count_ff + 48'd1;
            end else begin
               rsp_count_in = count_ff;
            end
            rsp_hit_in   = hit;
            rsp_valid_in = 1'b1;
         end
         default: begin
            gen_in = gen_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff      <= 16'd0;
         gen_ff       <= 64'd0;
         count_ff     <= 48'd0;
         tag_ff       <= mcpi_pkg::TAG_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         widx_ff      <= widx_in;
         gen_ff       <= gen_in;
         count_ff     <= count_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_ff       <= rep_in;
      acc_ff       <= acc_in;
      frac_ff      <= frac_in;
      sq_ff        <= sq_in;
      prod_ff      <= prod_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

// File: hw/rtl/monte_carlo_pi_sampler_top.sv
// Top level of the Monte Carlo pi sampler: sequencer plus datapath.
// One shared 32x32 multiplier carries all products; a start request also runs
//   the seeding steps. A new request is accepted only after the count step.
// Reset (synchronous, active high): generator state, hit count and worker index
//   clear to zero; no result pending.
module monte_carlo_pi_sampler_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_req,
   input  logic [15:0] req_rep_number,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [47:0] rsp_hit_count,
   // worker index register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_worker_index
);

   mcpi_pkg::cmd_type    cmd;
   mcpi_pkg::status_type status;

   // Register writes land at any time; the user must keep them between requests, as the block does not enforce this.
   assign csr_ready = 1'b1;

   // Sequencer: seeding steps run only for a start request, then two draws,
   // two squares and the compare/count step. The count step waits while an
   // earlier result is still stalled in the output register.
   mcpi_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath: xorshift64* state, product register whose product is accumulated
   // in the following cycle, exact Q1.106 sum of squares and the saturating hit counter.
   mcpi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_start_req    (req_start_req),
      .req_rep_number   (req_rep_number),
      .csr_valid        (csr_valid),
      .csr_worker_index (csr_worker_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_hit_count    (rsp_hit_count)
   );

endmodule
